// ===== rtl/lsg_pkg.sv =====
`timescale 1ns / 1ps
package lsg_pkg;

	localparam logic [2:0] OP_ELEM    = 3'd0;
	localparam logic [2:0] OP_LABEL   = 3'd1;
	localparam logic [2:0] OP_WEIGHT  = 3'd2;
	localparam logic [2:0] OP_COMPUTE = 3'd3;
	localparam logic [2:0] OP_CLEAR   = 3'd4;

	localparam logic [1:0] REG_NUM_EXAMPLES = 2'd0;
	localparam logic [1:0] REG_NUM_FEATURES = 2'd1;

	localparam logic [8:0] NUM_EXAMPLES_RST = 9'd256;
	localparam logic [5:0] NUM_FEATURES_RST = 6'd32;

	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
	localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

	typedef enum logic [9:0] {
		ST_CLR      = 10'b00_0000_0001,
		ST_IDLE     = 10'b00_0000_0010,
		ST_RES      = 10'b00_0000_0100,
		ST_DRAIN1   = 10'b00_0000_1000,
		ST_GRAD     = 10'b00_0001_0000,
		ST_DRAIN2   = 10'b00_0010_0000,
		ST_OUT_RD   = 10'b00_0100_0000,
		ST_OUT_LD   = 10'b00_1000_0000,
		ST_OUT_DIV  = 10'b01_0000_0000,
		ST_LOSS_DIV = 10'b10_0000_0000
	} state_t;

endpackage

// ===== rtl/lsg_ram.sv =====
`timescale 1ns / 1ps
module lsg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/lsg_div.sv =====
`timescale 1ns / 1ps
module lsg_div #(
	parameter int DW = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [63:0]  dividend,
	input  logic [DW-1:0]       divisor,
	output logic                done,
	output logic signed [31:0]  quotient
);

	logic          busy_q;
	logic          done_q;
	logic [5:0]    cnt_q;
	logic          neg_q;
	logic [63:0]   q_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] div_q;
	logic [DW:0]   rem_sh;
	logic [DW:0]   diff;
	logic          take;
	logic [63:0]   mag;

	assign mag    = dividend[63] ? (64'd0 - dividend) : dividend;
	assign rem_sh = {rem_q, q_q[63]};
	assign diff   = rem_sh - {1'b0, div_q};
	assign take   = rem_sh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 6'd63;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[63];
			q_q   <= mag;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			q_q   <= {q_q[62:0], take};
			rem_q <= take ? diff[DW-1:0] : rem_sh[DW-1:0];
		end
	end

	always_comb begin
		if (!neg_q && q_q > 64'd2147483647) begin
			quotient = 32'sh7FFF_FFFF;
		end else if (neg_q && q_q > 64'd2147483648) begin
			quotient = 32'sh8000_0000;
		end else if (neg_q) begin
			quotient = 32'(64'd0 - q_q);
		end else begin
			quotient = q_q[31:0];
		end
	end

	assign done = done_q;

endmodule

// ===== rtl/least_squares_gradient.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   operation, row_index, col_index, data_value
// out      output     out_valid/out_stall kind, feature, result_value, last
// cfg      input      cfg_write           cfg_index, cfg_data
//
// Load transactions are taken one per cycle while idle; a clear or compute transaction
// raises in_stall until the block is idle again. A compute walks the matrix twice, one element
// a cycle through the matrix memory port, then forms each result in the bit-serial divider.
// Reset and a clear transaction sweep the whole matrix memory, all 2**(row address bits +
// column address bits) words (8192 by default); in_stall is high meanwhile.
// A stalled output holds the sequencer; no result is dropped.
module least_squares_gradient #(
	parameter int MAX_EXAMPLES = 256,
	parameter int MAX_FEATURES = 32,
	parameter int FRAC_BITS    = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [8:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         operation,
	input  logic [7:0]         row_index,
	input  logic [4:0]         col_index,
	input  logic signed [31:0] data_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               kind,
	output logic [4:0]         feature,
	output logic signed [31:0] result_value,
	output logic               last
);

	localparam int RW = $clog2(MAX_EXAMPLES);
	localparam int CW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int AW = RW + CW;
	localparam int NW = $clog2(MAX_EXAMPLES + 1);
	localparam int FW = $clog2(MAX_FEATURES + 1);
	localparam int DW = NW + 1;

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		begin
			s = {a[63], a} + {b[63], b};
			if (s[64] != s[63]) begin
				sat_add = s[64] ? lsg_pkg::S64_MIN : lsg_pkg::S64_MAX;
			end else begin
				sat_add = s[63:0];
			end
		end
	endfunction

	lsg_pkg::state_t state_q;
	logic            clr_all_q;
	logic [AW-1:0]   sweep_q;
	logic [8:0]      ne_q;
	logic [5:0]      nf_q;
	logic [NW-1:0]   n_q;
	logic [FW-1:0]   f_q;
	logic [RW-1:0]   i_q;
	logic [CW-1:0]   j_q;

	logic            accept;
	logic            issue;
	logic [31:0]     row_ext;
	logic [31:0]     col_ext;
	logic            row_ok;
	logic            col_ok;
	logic [31:0]     n_full;
	logic [31:0]     f_full;
	logic [NW-1:0]   nm1;
	logic [FW-1:0]   fm1;
	logic            j_end;
	logic            i_end;

	logic            mat_we;
	logic [AW-1:0]   mat_wa;
	logic [31:0]     mat_wd;
	logic [31:0]     mat_rd;
	logic            lab_we;
	logic [RW-1:0]   lab_wa;
	logic [31:0]     lab_wd;
	logic [31:0]     lab_rd;
	logic            wgt_we;
	logic [CW-1:0]   wgt_wa;
	logic [31:0]     wgt_wd;
	logic [31:0]     wgt_rd;
	logic            res_we;
	logic [31:0]     res_wd;
	logic [31:0]     res_rd;
	logic            grd_we;
	logic [63:0]     grd_rd;

	logic            v_s1, ph_s1, fi_s1, fj_s1, lj_s1;
	logic [RW-1:0]   i_s1;
	logic [CW-1:0]   j_s1;
	logic            v_s2, ph_s2, fi_s2, fj_s2, lj_s2;
	logic [RW-1:0]   i_s2;
	logic [CW-1:0]   j_s2;
	logic signed [63:0] prod_s2;
	logic signed [63:0] sq_s2;
	logic signed [31:0] label_s2;
	logic signed [63:0] grd_s2;

	logic signed [63:0] acc_q;
	logic signed [63:0] loss_q;
	logic            w1_v_q, w2_v_q;
	logic [CW-1:0]   w1_j_q, w2_j_q;
	logic signed [63:0] w1_d_q, w2_d_q;

	logic signed [63:0] sh;
	logic signed [63:0] acc_sum;
	logic signed [63:0] res_full;
	logic signed [63:0] g_old;
	logic signed [63:0] g_new;
	logic signed [31:0] mul_b;

	logic            div_start;
	logic signed [63:0] div_dividend;
	logic [DW-1:0]   div_divisor;
	logic            div_done;
	logic signed [31:0] div_q;
	logic            slot_free;
	logic [31:0]     j_ext;

	assign in_stall = (state_q != lsg_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign issue    = (state_q == lsg_pkg::ST_RES) || (state_q == lsg_pkg::ST_GRAD);

	assign row_ext = 32'(row_index);
	assign col_ext = 32'(col_index);
	assign row_ok  = row_ext < MAX_EXAMPLES;
	assign col_ok  = col_ext < MAX_FEATURES;

	assign n_full = (ne_q == 9'd0) ? 32'd1 :
		((32'(ne_q) > MAX_EXAMPLES) ? MAX_EXAMPLES : 32'(ne_q));
	assign f_full = (nf_q == 6'd0) ? 32'd1 :
		((32'(nf_q) > MAX_FEATURES) ? MAX_FEATURES : 32'(nf_q));

	assign nm1   = n_q - NW'(1);
	assign fm1   = f_q - FW'(1);
	assign j_end = (j_q == fm1[CW-1:0]);
	assign i_end = (i_q == nm1[RW-1:0]);

	// Loads and clearing sweep
	always_comb begin
		mat_we = 1'b0;
		mat_wa = sweep_q;
		mat_wd = '0;
		lab_we = 1'b0;
		lab_wa = sweep_q[RW-1:0];
		lab_wd = '0;
		wgt_we = 1'b0;
		wgt_wa = sweep_q[CW-1:0];
		wgt_wd = '0;
		if (state_q == lsg_pkg::ST_CLR) begin
			mat_we = 1'b1;
			lab_we = clr_all_q;
			wgt_we = clr_all_q;
		end else if (accept) begin
			case (operation)
				lsg_pkg::OP_ELEM: begin
					mat_we = row_ok && col_ok;
					mat_wa = {row_ext[RW-1:0], col_ext[CW-1:0]};
					mat_wd = data_value;
				end
				lsg_pkg::OP_LABEL: begin
					lab_we = row_ok;
					lab_wa = row_ext[RW-1:0];
					lab_wd = data_value;
				end
				lsg_pkg::OP_WEIGHT: begin
					wgt_we = col_ok;
					wgt_wa = col_ext[CW-1:0];
					wgt_wd = data_value;
				end
				default: begin
				end
			endcase
		end
	end

	lsg_ram #(.WIDTH(32), .DEPTH(2 ** AW)) u_mat (
		.clk(clk), .we(mat_we), .waddr(mat_wa), .wdata(mat_wd),
		.raddr({i_q, j_q}), .rdata(mat_rd)
	);

	lsg_ram #(.WIDTH(32), .DEPTH(2 ** RW)) u_lab (
		.clk(clk), .we(lab_we), .waddr(lab_wa), .wdata(lab_wd),
		.raddr(i_q), .rdata(lab_rd)
	);

	lsg_ram #(.WIDTH(32), .DEPTH(2 ** CW)) u_wgt (
		.clk(clk), .we(wgt_we), .waddr(wgt_wa), .wdata(wgt_wd),
		.raddr(j_q), .rdata(wgt_rd)
	);

	lsg_ram #(.WIDTH(32), .DEPTH(2 ** RW)) u_res (
		.clk(clk), .we(res_we), .waddr(i_s2), .wdata(res_wd),
		.raddr(i_q), .rdata(res_rd)
	);

	lsg_ram #(.WIDTH(64), .DEPTH(2 ** CW)) u_grd (
		.clk(clk), .we(grd_we), .waddr(j_s2), .wdata(g_new),
		.raddr(j_q), .rdata(grd_rd)
	);

	// Stage 1: multiply
	assign mul_b = ph_s1 ? res_rd : wgt_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		ph_s1    <= (state_q == lsg_pkg::ST_GRAD);
		i_s1     <= i_q;
		j_s1     <= j_q;
		fi_s1    <= (i_q == '0);
		fj_s1    <= (j_q == '0);
		lj_s1    <= j_end;
		ph_s2    <= ph_s1;
		i_s2     <= i_s1;
		j_s2     <= j_s1;
		fi_s2    <= fi_s1;
		fj_s2    <= fj_s1;
		lj_s2    <= lj_s1;
		prod_s2  <= $signed(mat_rd) * mul_b;
		sq_s2    <= $signed(res_rd) * $signed(res_rd);
		label_s2 <= lab_rd;
		grd_s2   <= grd_rd;
	end

	// Stage 2: accumulate, with forwarding of recent gradient writes
	assign sh      = prod_s2 >>> FRAC_BITS;
	assign acc_sum = (fj_s2 ? 64'sd0 : acc_q) + sh;
	assign res_full = acc_sum - 64'(label_s2);
	assign res_wd  = (res_full > lsg_pkg::S32_MAX) ? 32'sh7FFF_FFFF :
		((res_full < lsg_pkg::S32_MIN) ? 32'sh8000_0000 : res_full[31:0]);
	assign res_we  = v_s2 && !ph_s2 && lj_s2;

	always_comb begin
		if (fi_s2) begin
			g_old = '0;
		end else if (w1_v_q && w1_j_q == j_s2) begin
			g_old = w1_d_q;
		end else if (w2_v_q && w2_j_q == j_s2) begin
			g_old = w2_d_q;
		end else begin
			g_old = grd_s2;
		end
	end

	assign g_new  = sat_add(g_old, sh);
	assign grd_we = v_s2 && ph_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w1_v_q <= 1'b0;
			w2_v_q <= 1'b0;
		end else begin
			w1_v_q <= grd_we;
			w2_v_q <= w1_v_q;
		end
	end

	always_ff @(posedge clk) begin
		w1_j_q <= j_s2;
		w1_d_q <= g_new;
		w2_j_q <= w1_j_q;
		w2_d_q <= w1_d_q;
		if (v_s2 && !ph_s2) begin
			acc_q <= acc_sum;
		end
		if (v_s2 && ph_s2 && fj_s2) begin
			loss_q <= sat_add(fi_s2 ? 64'sd0 : loss_q, sq_s2 >>> FRAC_BITS);
		end
	end

	// Division and result register
	assign slot_free = !out_valid || !out_stall;
	assign j_ext     = 32'(j_q);

	always_comb begin
		div_start    = 1'b0;
		div_dividend = grd_rd;
		div_divisor  = {1'b0, n_q};
		if (state_q == lsg_pkg::ST_OUT_LD) begin
			div_start = 1'b1;
		end else if (state_q == lsg_pkg::ST_OUT_DIV && div_done && slot_free && j_end) begin
			div_start    = 1'b1;
			div_dividend = loss_q;
			div_divisor  = {n_q, 1'b0};
		end
	end

	lsg_div #(.DW(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dividend),
		.divisor(div_divisor), .done(div_done), .quotient(div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if ((state_q == lsg_pkg::ST_OUT_DIV || state_q == lsg_pkg::ST_LOSS_DIV)
			&& div_done && slot_free) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lsg_pkg::ST_OUT_DIV && div_done && slot_free) begin
			kind         <= 1'b0;
			feature      <= j_ext[4:0];
			result_value <= div_q;
			last         <= 1'b0;
		end else if (state_q == lsg_pkg::ST_LOSS_DIV && div_done && slot_free) begin
			kind         <= 1'b1;
			feature      <= '0;
			result_value <= div_q;
			last         <= 1'b1;
		end
	end

	// Configuration and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ne_q <= lsg_pkg::NUM_EXAMPLES_RST;
			nf_q <= lsg_pkg::NUM_FEATURES_RST;
		end else if (cfg_write) begin
			if (cfg_index == lsg_pkg::REG_NUM_EXAMPLES) begin
				ne_q <= cfg_data;
			end else if (cfg_index == lsg_pkg::REG_NUM_FEATURES) begin
				nf_q <= cfg_data[5:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lsg_pkg::ST_CLR;
			clr_all_q <= 1'b1;
			sweep_q   <= '0;
			n_q       <= '0;
			f_q       <= '0;
			i_q       <= '0;
			j_q       <= '0;
		end else begin
			case (state_q)
				lsg_pkg::ST_CLR: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == '1) begin
						clr_all_q <= 1'b0;
						state_q   <= lsg_pkg::ST_IDLE;
					end
				end
				lsg_pkg::ST_IDLE: begin
					if (accept && operation == lsg_pkg::OP_COMPUTE) begin
						n_q     <= n_full[NW-1:0];
						f_q     <= f_full[FW-1:0];
						i_q     <= '0;
						j_q     <= '0;
						state_q <= lsg_pkg::ST_RES;
					end else if (accept && operation == lsg_pkg::OP_CLEAR) begin
						sweep_q <= '0;
						state_q <= lsg_pkg::ST_CLR;
					end
				end
				lsg_pkg::ST_RES, lsg_pkg::ST_GRAD: begin
					if (j_end) begin
						j_q <= '0;
						if (i_end) begin
							i_q     <= '0;
							state_q <= (state_q == lsg_pkg::ST_RES) ?
								lsg_pkg::ST_DRAIN1 : lsg_pkg::ST_DRAIN2;
						end else begin
							i_q <= i_q + RW'(1);
						end
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
				lsg_pkg::ST_DRAIN1: begin
					if (!v_s1 && !v_s2) begin
						state_q <= lsg_pkg::ST_GRAD;
					end
				end
				lsg_pkg::ST_DRAIN2: begin
					if (!v_s1 && !v_s2) begin
						state_q <= lsg_pkg::ST_OUT_RD;
					end
				end
				lsg_pkg::ST_OUT_RD: begin
					state_q <= lsg_pkg::ST_OUT_LD;
				end
				lsg_pkg::ST_OUT_LD: begin
					state_q <= lsg_pkg::ST_OUT_DIV;
				end
				lsg_pkg::ST_OUT_DIV: begin
					if (div_done && slot_free) begin
						if (j_end) begin
							j_q     <= '0;
							state_q <= lsg_pkg::ST_LOSS_DIV;
						end else begin
							j_q     <= j_q + CW'(1);
							state_q <= lsg_pkg::ST_OUT_RD;
						end
					end
				end
				lsg_pkg::ST_LOSS_DIV: begin
					if (div_done && slot_free) begin
						state_q <= lsg_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= lsg_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== dv/least_squares_gradient_tb.sv =====
`timescale 1ns / 1ps
module least_squares_gradient_tb;

	localparam int ROWS = 256;
	localparam int COLS = 32;
	localparam int IDLE_LIMIT = 120000;
	localparam int LONG_HOLD = 2000;
	localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
	localparam logic [2:0] OP_RSVD_LAST  = 3'd7;
	localparam logic [1:0] REG_SPARE_FIRST = 2'd2;
	localparam logic [1:0] REG_SPARE_LAST  = 2'd3;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  row;
		logic [4:0]  col;
		logic [31:0] data;
	} txn_t;

	typedef struct packed {
		logic        kind;
		logic [4:0]  feat;
		logic [31:0] val;
		logic        last;
	} result_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_write = 0;
	logic [1:0] cfg_index = '0;
	logic [8:0] cfg_data = '0;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [2:0] operation;
	logic [7:0] row_index;
	logic [4:0] col_index;
	logic signed [31:0] data_value;
	logic kind, last;
	logic [4:0] feature;
	logic signed [31:0] result_value;

	txn_t pending_q[$];
	result_t grad_q[$];
	txn_t cur;
	int send_gap, recv_run, hold_left, n_results, errors, idle_cyc;
	bit held_once, calm;

	logic signed [31:0] mtx [ROWS][COLS];
	logic signed [31:0] lab [ROWS];
	logic signed [31:0] wt [COLS];
	logic [8:0] n_ex = lsg_pkg::NUM_EXAMPLES_RST;
	logic [5:0] n_ft = lsg_pkg::NUM_FEATURES_RST;

	least_squares_gradient u_top (.*);

	always #2 clk = ~clk;

	function automatic int rows_used();
		if (n_ex == 0) return 1;
		return (n_ex > ROWS) ? ROWS : int'(n_ex);
	endfunction

	function automatic int cols_used();
		if (n_ft == 0) return 1;
		return (n_ft > COLS) ? COLS : int'(n_ft);
	endfunction

	function automatic longint qfloor(longint x);
		return x >>> 16;
	endfunction

	function automatic longint clip32(longint x);
		if (x > lsg_pkg::S32_MAX) return lsg_pkg::S32_MAX;
		if (x < lsg_pkg::S32_MIN) return lsg_pkg::S32_MIN;
		return x;
	endfunction

	function automatic longint add_sat(longint a, longint b);
		logic signed [64:0] s;
		s = a;
		s = s + b;
		if (s > lsg_pkg::S64_MAX) return lsg_pkg::S64_MAX;
		if (s < lsg_pkg::S64_MIN) return lsg_pkg::S64_MIN;
		return longint'(s);
	endfunction

	task automatic predict_gradient();
		longint res [ROWS];
		longint gsum [COLS];
		longint lsum, acc;
		int n, f;
		result_t e;
		n = rows_used();
		f = cols_used();
		lsum = 0;
		for (int j = 0; j < COLS; j++) gsum[j] = 0;
		for (int i = 0; i < n; i++) begin
			acc = 0;
			for (int j = 0; j < f; j++)
				acc += qfloor(longint'(mtx[i][j]) * longint'(wt[j]));
			res[i] = clip32(acc - longint'(lab[i]));
		end
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < f; j++)
				gsum[j] = add_sat(gsum[j], qfloor(longint'(mtx[i][j]) * res[i]));
			lsum = add_sat(lsum, qfloor(res[i] * res[i]));
		end
		for (int j = 0; j < f; j++) begin
			e.kind = 1'b0;
			e.feat = j[4:0];
			e.val = 32'(clip32(gsum[j] / longint'(n)));
			e.last = 1'b0;
			grad_q.push_back(e);
		end
		e.kind = 1'b1;
		e.feat = '0;
		e.val = 32'(clip32(lsum / longint'(2 * n)));
		e.last = 1'b1;
		grad_q.push_back(e);
	endtask

	task automatic apply_txn(txn_t t);
		case (t.op)
			lsg_pkg::OP_ELEM: mtx[t.row][t.col] = t.data;
			lsg_pkg::OP_LABEL: lab[t.row] = t.data;
			lsg_pkg::OP_WEIGHT: wt[t.col] = t.data;
			lsg_pkg::OP_CLEAR: begin
				foreach (mtx[i, j]) mtx[i][j] = '0;
			end
			lsg_pkg::OP_COMPUTE: predict_gradient();
			default: ;
		endcase
	endtask

	function automatic int pick_len();
		int r;
		r = $urandom_range(99);
		if (calm || r < 65) return 0;
		if (r < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			operation <= '0;
			row_index <= '0;
			col_index <= '0;
			data_value <= '0;
			send_gap = 0;
		end else begin
			if (in_valid && !in_stall) apply_txn(cur);
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_q.size() != 0) begin
					cur = pending_q.pop_front();
					operation <= cur.op;
					row_index <= cur.row;
					col_index <= cur.col;
					data_value <= cur.data;
					in_valid <= 1'b1;
					send_gap = pick_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_run = 0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				n_results++;
				if (grad_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected transaction: kind %0d feature %0d value %0d",
							kind, feature, result_value);
				end else begin
					e = grad_q.pop_front();
					if (kind !== e.kind || feature !== e.feat || result_value !== e.val
							|| last !== e.last) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
								e.kind, e.feat, $signed(e.val), e.last,
								kind, feature, result_value, last);
					end
				end
			end
			if (!held_once && n_results >= 10) begin
				held_once = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (recv_run > 0) begin
				recv_run--;
				out_stall <= 1'b1;
			end else begin
				recv_run = pick_len();
				out_stall <= (recv_run > 0);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
			idle_cyc = 0;
		else
			idle_cyc++;
		if (idle_cyc >= IDLE_LIMIT) begin
			$display("least_squares_gradient_tb failed");
			$finish;
		end
	end

	task automatic cfg_set(logic [1:0] idx, logic [8:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == lsg_pkg::REG_NUM_EXAMPLES) n_ex = val;
		else if (idx == lsg_pkg::REG_NUM_FEATURES) n_ft = val[5:0];
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic drain();
		do @(posedge clk); while (pending_q.size() != 0 || in_valid || grad_q.size() != 0);
		repeat (20) @(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic push(logic [2:0] op, logic [7:0] row, logic [4:0] col, logic [31:0] d);
		txn_t t;
		t.op = op;
		t.row = row;
		t.col = col;
		t.data = d;
		pending_q.push_back(t);
	endtask

	function automatic txn_t rand_txn();
		txn_t t;
		int r, nr, nc;
		nr = rows_used();
		nc = cols_used();
		r = $urandom_range(99);
		if (r < 40) t.op = lsg_pkg::OP_ELEM;
		else if (r < 55) t.op = lsg_pkg::OP_LABEL;
		else if (r < 75) t.op = lsg_pkg::OP_WEIGHT;
		else if (r < 89) t.op = lsg_pkg::OP_COMPUTE;
		else if (r < 92) t.op = lsg_pkg::OP_CLEAR;
		else t.op = 3'($urandom_range(OP_RSVD_LAST, OP_RSVD_FIRST));
		t.row = ($urandom_range(99) < 80) ? 8'($urandom_range(nr - 1)) : 8'($urandom);
		t.col = ($urandom_range(99) < 80) ? 5'($urandom_range(nc - 1)) : 5'($urandom);
		r = $urandom_range(99);
		if (r < 40) t.data = $urandom;
		else if (r < 75) t.data = 32'($urandom_range(32'h3FFFF)) - 32'h20000;
		else if (r < 88) begin
			case ($urandom_range(3))
				0: t.data = 32'h7FFF_FFFF;
				1: t.data = 32'h8000_0000;
				2: t.data = 32'h0;
				default: t.data = 32'hFFFF_FFFF;
			endcase
		end else begin
			t.data = 32'($urandom_range(8)) << 16;
			if ($urandom_range(1)) t.data = -t.data;
		end
		return t;
	endfunction

	task automatic run_phase(logic [8:0] ne, logic [5:0] nf, int count, bit quiet);
		cfg_set(lsg_pkg::REG_NUM_EXAMPLES, ne);
		cfg_set(lsg_pkg::REG_NUM_FEATURES, {3'b0, nf});
		@(negedge clk);
		calm = quiet;
		for (int k = 0; k < count; k++) pending_q.push_back(rand_txn());
		push(lsg_pkg::OP_COMPUTE, '0, '0, '0);
		drain();
	endtask

	initial begin
		foreach (mtx[i, j]) mtx[i][j] = '0;
		foreach (lab[i]) lab[i] = '0;
		foreach (wt[i]) wt[i] = '0;
		calm = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// full-size corners at reset configuration
		push(lsg_pkg::OP_ELEM, 8'd0, 5'd0, 32'h7FFF_FFFF);
		push(lsg_pkg::OP_ELEM, 8'd255, 5'd31, 32'h8000_0000);
		push(lsg_pkg::OP_ELEM, 8'd1, 5'd1, 32'h0001_0000);
		push(lsg_pkg::OP_ELEM, 8'd2, 5'd3, 32'hFFFF_FFFF);
		push(lsg_pkg::OP_LABEL, 8'd0, 5'd0, 32'h8000_0000);
		push(lsg_pkg::OP_LABEL, 8'd255, 5'd31, 32'h7FFF_FFFF);
		push(lsg_pkg::OP_WEIGHT, 8'd0, 5'd0, 32'h7FFF_FFFF);
		push(lsg_pkg::OP_WEIGHT, 8'd0, 5'd31, 32'h8000_0000);
		push(lsg_pkg::OP_WEIGHT, 8'd255, 5'd1, 32'h0002_0000);
		push(lsg_pkg::OP_COMPUTE, 8'hFF, 5'h1F, 32'hFFFF_FFFF);
		push(OP_RSVD_FIRST, 8'd3, 5'd3, 32'h1234_5678);
		push(OP_RSVD_FIRST + 3'd1, 8'd0, 5'd0, 32'h0);
		push(OP_RSVD_LAST, 8'd1, 5'd1, 32'hDEAD_BEEF);
		push(lsg_pkg::OP_CLEAR, 8'd0, 5'd0, 32'h0);
		push(lsg_pkg::OP_LABEL, 8'd1, 5'd0, 32'h0003_0000);
		push(lsg_pkg::OP_COMPUTE, 8'd0, 5'd0, 32'h0);
		drain();
		// spare register indexes are ignored
		cfg_set(REG_SPARE_FIRST, 9'($urandom));
		cfg_set(REG_SPARE_LAST, 9'($urandom));
		run_phase(9'd0, 6'd0, 10, 1'b0);
		run_phase(9'd1, 6'd1, 10, 1'b0);
		run_phase(9'd511, 6'd63, 6, 1'b0);
		run_phase(9'd3, 6'd4, 30, 1'b0);
		run_phase(9'd5, 6'd8, 30, 1'b0);
		run_phase(9'd2, 6'd2, 30, 1'b1);
		run_phase(9'd8, 6'd6, 30, 1'b0);
		run_phase(9'd4, 6'd3, 30, 1'b0);
		repeat (200) @(posedge clk);
		if (errors == 0 && grad_q.size() == 0)
			$display("least_squares_gradient_tb passed");
		else
			$display("least_squares_gradient_tb failed");
		$finish;
	end

endmodule
